// File: rtl/byte_vm_instruction_execute_top_assert.svh
// Assertion macros for the byte machine execute block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BYTE_VM_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
`define BYTE_VM_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define BVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define BVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bvm_pkg.sv
// Shared types, constants and helpers of the byte machine execute block.
// No dependencies; imported by the top level and the testbench.
package bvm_pkg;

    // Storage sizes
    localparam int DATA_DEPTH    = 256;
    localparam int PROGRAM_DEPTH = 256;
    localparam int ADDR_W        = $clog2(DATA_DEPTH);

    // Field widths
    localparam int DATA_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int PC_W     = 9;
    localparam int STATUS_W = 2;
    localparam int TGT_W    = PC_W + 2;
    localparam int CNT_W    = $clog2(DATA_W);

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_MOVE   = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD    = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB    = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_MUL    = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_DIV    = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_JUMP   = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_BR_Z   = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_BR_NZ  = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_BR_POS = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_BR_NEG = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_OUT    = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_IN     = 4'd11;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_RUN    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FINISH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAULT  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_OPND,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    // Reduce an address byte modulo the data depth (depth is at least 16)
    function automatic logic [ADDR_W-1:0] data_addr(input logic [DATA_W-1:0] b);
        logic [15:0] r;
        r = 16'(b);
        for (int k = 3; k >= 0; k--) begin
            if (r >= 16'(DATA_DEPTH << k)) begin
                r = r - 16'(DATA_DEPTH << k);
            end
        end
        return r[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/bvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/byte_vm_instruction_execute_top.sv
// Byte machine instruction execute: top level with sequencer, ALU and divider.
// Depends on bvm_pkg, bvm_ram and byte_vm_instruction_execute_top_assert.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  in      | into      | i_in_valid / o_in_stall   | opcode, operand flags and bytes
//  out     | out of    | o_out_valid / i_out_stall | next_pc, status, char, patch
//  cfg     | into      | i_cfg_valid / o_cfg_ready | program_length
//
// An item passes accept, first operand read, second operand read and execute,
// then commit; a divide also passes the bit-serial divider before commit.
// The single read port of the data memory serializes the two operand reads.
// Reset clears the pc, the fault flag, the length and the memory valid bits.
// The next item is taken while a finished result waits in the output register;
// a stalled output holds the following result in the commit state.
`include "byte_vm_instruction_execute_top_assert.svh"

module byte_vm_instruction_execute_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input item channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bvm_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic                            i_first_in_memory,
    input  logic                            i_second_in_memory,
    input  logic [bvm_pkg::DATA_W-1:0]      i_first_byte,
    input  logic [bvm_pkg::DATA_W-1:0]      i_second_byte,
    input  logic [bvm_pkg::DATA_W-1:0]      i_input_char,
    // Result item channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bvm_pkg::PC_W-1:0]        o_next_pc,
    output logic [bvm_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_char_valid,
    output logic [bvm_pkg::DATA_W-1:0]      o_char_out,
    output logic                            o_patch_valid,
    output logic [bvm_pkg::DATA_W-1:0]      o_patch_value,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bvm_pkg::PC_W-1:0]        i_program_length
);

    import bvm_pkg::*;

    // Architectural state
    t_state                r_state, n_state;
    logic [PC_W-1:0]       r_pc;
    logic                  r_faulted;
    logic [PC_W-1:0]       r_prog_len;
    logic [DATA_DEPTH-1:0] r_valid;
    logic                  r_rd_valid;

    // Latched instruction
    logic [OPCODE_W-1:0]   r_opcode;
    logic                  r_f1, r_f2;
    logic [DATA_W-1:0]     r_b1, r_b2, r_ch;
    logic [DATA_W-1:0]     r_v1;

    // Execute results awaiting commit
    logic [PC_W-1:0]       r_ex_pc;
    logic [STATUS_W-1:0]   r_ex_status;
    logic                  r_ex_char_valid;
    logic [DATA_W-1:0]     r_ex_char;
    logic                  r_ex_mem_wr;
    logic                  r_ex_patch;
    logic                  r_ex_fault;
    logic [DATA_W-1:0]     r_res;

    // Divider
    logic [CNT_W-1:0]      r_div_cnt;
    logic [DATA_W-1:0]     r_quo, r_dvs, r_rem;
    logic                  r_qneg;
    logic [DATA_W:0]       div_shift;
    logic                  div_bit;
    logic [DATA_W-1:0]     div_rem, div_quo;

    // Output register
    logic                  r_out_valid;
    logic [PC_W-1:0]       r_out_pc;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_out_char_valid;
    logic [DATA_W-1:0]     r_out_char;
    logic                  r_out_patch_valid;
    logic [DATA_W-1:0]     r_out_patch;

    // Control
    logic                  in_accept;
    logic                  out_free;
    logic                  commit;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_W-1:0]     ram_rdata;
    logic [DATA_W-1:0]     mem_byte;

    // Execute datapath
    logic [DATA_W-1:0]       v2;
    logic signed [TGT_W-1:0] s1_ext, s2_ext, pc_ext, tgt;
    logic [PC_W-1:0]         lim, sat_pc;
    logic [DATA_W-1:0]       alu_res;
    logic [2*DATA_W-1:0]     mul_full;
    logic                    ex_wr, ex_bad, ex_div;
    logic [PC_W-1:0]         ex_pc;
    logic [STATUS_W-1:0]     ex_status;
    logic                    ex_char_valid;
    logic [DATA_W-1:0]       ex_char;
    logic                    ex_mem_wr, ex_patch, ex_fault;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    bvm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_res),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Memory byte reads as zero until written
    assign mem_byte  = r_rd_valid ? ram_rdata : '0;
    assign ram_waddr = data_addr(r_b1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_accept) n_state = S_OPND;
            S_OPND: n_state = S_EXEC;
            S_EXEC: n_state = ex_div ? S_DIV : S_DONE;
            S_DIV:  if (r_div_cnt == CNT_W'(DATA_W - 1)) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        ram_raddr  = data_addr(r_b2);
        commit     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                ram_raddr  = data_addr(i_first_byte);
            end
            S_DONE: commit = out_free;
            default: ;
        endcase
        ram_we = commit && r_ex_mem_wr;
    end

    // Operand two and the combinational ALU
    always_comb begin
        v2       = r_f2 ? mem_byte : r_b2;
        mul_full = r_v1 * v2;
        s1_ext   = TGT_W'($signed(r_v1));
        s2_ext   = TGT_W'($signed(v2));
        pc_ext   = $signed({2'b00, r_pc});
        lim      = (r_prog_len > PC_W'(PROGRAM_DEPTH)) ? PC_W'(PROGRAM_DEPTH) : r_prog_len;
        alu_res  = '0;
        ex_wr    = 1'b0;
        ex_bad   = 1'b0;
        ex_div   = 1'b0;
        ex_char_valid = 1'b0;
        ex_char  = '0;
        tgt      = pc_ext + TGT_W'(1);
        unique case (r_opcode)
            OP_MOVE: begin
                alu_res = v2;
                ex_wr   = 1'b1;
            end
            OP_ADD: begin
                alu_res = r_v1 + v2;
                ex_wr   = 1'b1;
            end
            OP_SUB: begin
                alu_res = r_v1 - v2;
                ex_wr   = 1'b1;
            end
            OP_MUL: begin
                alu_res = mul_full[DATA_W-1:0];
                ex_wr   = 1'b1;
            end
            OP_DIV: begin
                if (v2 == '0) begin
                    ex_bad = 1'b1;
                end else begin
                    ex_div = 1'b1;
                    ex_wr  = 1'b1;
                end
            end
            OP_JUMP:   tgt = s1_ext;
            OP_BR_Z:   if (r_v1 == '0) tgt = pc_ext + s2_ext;
            OP_BR_NZ:  if (r_v1 != '0) tgt = pc_ext + s2_ext;
            OP_BR_POS: if (!r_v1[DATA_W-1] && r_v1 != '0) tgt = pc_ext + s2_ext;
            OP_BR_NEG: if (r_v1[DATA_W-1]) tgt = pc_ext + s2_ext;
            OP_OUT: begin
                ex_char_valid = 1'b1;
                ex_char       = r_v1;
            end
            OP_IN: begin
                alu_res = r_ch;
                ex_wr   = 1'b1;
            end
            default: ;
        endcase
        if (tgt < 0) begin
            ex_bad = 1'b1;
        end
        sat_pc = (tgt > TGT_W'(PROGRAM_DEPTH)) ? PC_W'(PROGRAM_DEPTH) : tgt[PC_W-1:0];

        // Resolve halted, faulting and normal cases
        ex_fault  = 1'b0;
        ex_mem_wr = 1'b0;
        ex_patch  = 1'b0;
        ex_pc     = r_pc;
        if (r_faulted) begin
            ex_status     = ST_FAULT;
            ex_char_valid = 1'b0;
            ex_char       = '0;
            ex_div        = 1'b0;
        end else if (r_pc >= lim) begin
            ex_status     = ST_FINISH;
            ex_char_valid = 1'b0;
            ex_char       = '0;
            ex_div        = 1'b0;
        end else if (ex_bad) begin
            ex_status     = ST_FAULT;
            ex_fault      = 1'b1;
            ex_char_valid = 1'b0;
            ex_char       = '0;
            ex_div        = 1'b0;
        end else begin
            ex_pc     = sat_pc;
            ex_status = (sat_pc >= lim) ? ST_FINISH : ST_RUN;
            ex_mem_wr = ex_wr && r_f1;
            ex_patch  = ex_wr && !r_f1;
        end
    end

    // One restoring division step on magnitudes
    always_comb begin
        div_shift = {r_rem, r_quo[DATA_W-1]};
        div_bit   = div_shift >= {1'b0, r_dvs};
        div_rem   = div_bit ? DATA_W'(div_shift - {1'b0, r_dvs}) : div_shift[DATA_W-1:0];
        div_quo   = {r_quo[DATA_W-2:0], div_bit};
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_faulted   <= 1'b0;
            r_prog_len  <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_prog_len <= i_program_length;
            end
            // Advance the divider count; it wraps back to zero after the last step
            if (r_state == S_DIV) begin
                r_div_cnt <= r_div_cnt + CNT_W'(1);
            end
            // Commit state and hand the result to the output register
            if (commit) begin
                r_pc        <= r_ex_pc;
                r_faulted   <= r_faulted || r_ex_fault;
                r_out_valid <= 1'b1;
                if (r_ex_mem_wr) begin
                    r_valid[ram_waddr] <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[ram_raddr];
        if (in_accept) begin
            r_opcode <= i_opcode;
            r_f1     <= i_first_in_memory;
            r_f2     <= i_second_in_memory;
            r_b1     <= i_first_byte;
            r_b2     <= i_second_byte;
            r_ch     <= i_input_char;
        end
        if (r_state == S_OPND) begin
            r_v1 <= r_f1 ? mem_byte : r_b1;
        end
        if (r_state == S_EXEC) begin
            r_ex_pc         <= ex_pc;
            r_ex_status     <= ex_status;
            r_ex_char_valid <= ex_char_valid;
            r_ex_char       <= ex_char;
            r_ex_mem_wr     <= ex_mem_wr;
            r_ex_patch      <= ex_patch;
            r_ex_fault      <= ex_fault;
            r_res           <= alu_res;
            // Load magnitudes for the divider
            r_quo  <= r_v1[DATA_W-1] ? DATA_W'(-r_v1) : r_v1;
            r_dvs  <= v2[DATA_W-1] ? DATA_W'(-v2) : v2;
            r_rem  <= '0;
            r_qneg <= r_v1[DATA_W-1] ^ v2[DATA_W-1];
        end
        if (r_state == S_DIV) begin
            r_rem <= div_rem;
            r_quo <= div_quo;
            if (r_div_cnt == CNT_W'(DATA_W - 1)) begin
                r_res <= r_qneg ? DATA_W'(-div_quo) : div_quo;
            end
        end
        if (commit) begin
            r_out_pc          <= r_ex_pc;
            r_out_status      <= r_ex_status;
            r_out_char_valid  <= r_ex_char_valid;
            r_out_char        <= r_ex_char;
            r_out_patch_valid <= r_ex_patch;
            r_out_patch       <= r_ex_patch ? r_res : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out_pc;
    assign o_status      = r_out_status;
    assign o_char_valid  = r_out_char_valid;
    assign o_char_out    = r_out_char;
    assign o_patch_valid = r_out_patch_valid;
    assign o_patch_value = r_out_patch;

    // Checks
    `BVM_ASSERT_NEXT(a_fault_sticky, i_clk, i_rst_n, r_faulted, r_faulted,
        "fault flag cleared without reset")
    `BVM_ASSERT_NEXT(a_write_with_result, i_clk, i_rst_n, ram_we, r_out_valid,
        "memory written without a result being issued")
    `BVM_ASSERT_NOW(a_fault_quiet, i_clk, i_rst_n, r_out_valid && r_out_status == ST_FAULT,
        !r_out_char_valid && !r_out_patch_valid, "faulted result carries a side effect")
    `BVM_ASSERT_NOW(a_pc_range, i_clk, i_rst_n, r_out_valid,
        r_out_pc <= PC_W'(PROGRAM_DEPTH), "next pc beyond program depth")
    `BVM_ASSERT_NOW(a_div_idle, i_clk, i_rst_n, r_state != S_DIV, r_div_cnt == '0,
        "divider count running outside the divide state")

endmodule

// File: verif/tb_byte_vm_instruction_execute_top.sv
// Self-checking testbench for byte_vm_instruction_execute_top.
// A scoreboard class predicts each result item from its own copy of the
// machine state; depends on bvm_pkg and the top level RTL only.
`timescale 1ns / 100ps

module tb_byte_vm_instruction_execute_top;
    import bvm_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 720;
    localparam int IDLE_PERCENT   = 31;
    localparam int QUIET_FROM     = 150;
    localparam int QUIET_TO       = 330;
    localparam int HOLD_AT        = 200;
    localparam int HOLD_CYCLES    = 160;
    localparam int SETTLE_CYCLES  = 24;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int REPORT_LIMIT   = 60;

    // Opcodes without a function; they only advance the pc
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd12;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                first_mem;
        logic                second_mem;
        logic [DATA_W-1:0]   first_byte;
        logic [DATA_W-1:0]   second_byte;
        logic [DATA_W-1:0]   input_char;
    } t_instr;

    typedef struct packed {
        logic [PC_W-1:0]     next_pc;
        logic [STATUS_W-1:0] status;
        logic                char_valid;
        logic [DATA_W-1:0]   char_out;
        logic                patch_valid;
        logic [DATA_W-1:0]   patch_value;
    } t_result;

    // Machine state copy, expected result queue and comparison
    class exec_scoreboard;
        logic [DATA_W-1:0] scratch [DATA_DEPTH];
        int unsigned       pc;
        bit                trapped;
        int unsigned       length_reg;
        t_result           expected_results[$];
        int unsigned       mismatches;

        function new();
            foreach (scratch[k]) scratch[k] = '0;
            pc = 0;
            trapped = 1'b0;
            length_reg = 0;
            mismatches = 0;
        endfunction

        function int unsigned effective_length();
            return (length_reg < PROGRAM_DEPTH) ? length_reg : PROGRAM_DEPTH;
        endfunction

        function bit halted();
            return trapped || (pc >= effective_length());
        endfunction

        // Execute one instruction; update the state only when commit is set
        function t_result run_instr(t_instr it, bit commit);
            t_result           r;
            logic [DATA_W-1:0] v1, v2, wval;
            int                s1, s2, target;
            bit                wr, fault;
            r = '0;
            wval = '0;
            wr = 1'b0;
            fault = 1'b0;
            if (trapped) begin
                r.next_pc = PC_W'(pc);
                r.status = ST_FAULT;
                return r;
            end
            if (pc >= effective_length()) begin
                r.next_pc = PC_W'(pc);
                r.status = ST_FINISH;
                return r;
            end
            v1 = it.first_mem ? scratch[it.first_byte % DATA_DEPTH] : it.first_byte;
            v2 = it.second_mem ? scratch[it.second_byte % DATA_DEPTH] : it.second_byte;
            s1 = $signed(v1);
            s2 = $signed(v2);
            target = int'(pc) + 1;
            case (it.opcode)
                OP_MOVE: begin
                    wval = v2;
                    wr = 1'b1;
                end
                OP_ADD: begin
                    wval = v1 + v2;
                    wr = 1'b1;
                end
                OP_SUB: begin
                    wval = v1 - v2;
                    wr = 1'b1;
                end
                OP_MUL: begin
                    wval = v1 * v2;
                    wr = 1'b1;
                end
                OP_DIV: begin
                    if (v2 == '0) begin
                        fault = 1'b1;
                    end else begin
                        wval = DATA_W'(s1 / s2);
                        wr = 1'b1;
                    end
                end
                OP_JUMP:   target = s1;
                OP_BR_Z:   if (s1 == 0) target = int'(pc) + s2;
                OP_BR_NZ:  if (s1 != 0) target = int'(pc) + s2;
                OP_BR_POS: if (s1 > 0) target = int'(pc) + s2;
                OP_BR_NEG: if (s1 < 0) target = int'(pc) + s2;
                OP_OUT: begin
                    r.char_valid = 1'b1;
                    r.char_out = v1;
                end
                OP_IN: begin
                    wval = it.input_char;
                    wr = 1'b1;
                end
                default: ;
            endcase
            // Divide by zero or a negative target: trap and hold the pc
            if (fault || target < 0) begin
                if (commit) trapped = 1'b1;
                r = '0;
                r.next_pc = PC_W'(pc);
                r.status = ST_FAULT;
                return r;
            end
            if (wr) begin
                if (it.first_mem) begin
                    if (commit) scratch[it.first_byte % DATA_DEPTH] = wval;
                end else begin
                    r.patch_valid = 1'b1;
                    r.patch_value = wval;
                end
            end
            // Saturate a target past the program store
            if (target > PROGRAM_DEPTH) target = PROGRAM_DEPTH;
            if (commit) pc = target;
            r.next_pc = PC_W'(target);
            r.status = (target >= int'(effective_length())) ? ST_FINISH : ST_RUN;
            return r;
        endfunction

        function void note_instr(t_instr it);
            expected_results.push_back(run_instr(it, 1'b1));
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                             $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result item, expected none, actual 0x%0h",
                             $time, got);
                return;
            end
            want = expected_results.pop_front();
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("status", want.status, got.status);
            compare_field("char_valid", want.char_valid, got.char_valid);
            compare_field("char_out", want.char_out, got.char_out);
            compare_field("patch_valid", want.patch_valid, got.patch_valid);
            compare_field("patch_value", want.patch_value, got.patch_value);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [OPCODE_W-1:0] i_opcode = '0;
    logic                i_first_in_memory = 1'b0;
    logic                i_second_in_memory = 1'b0;
    logic [DATA_W-1:0]   i_first_byte = '0;
    logic [DATA_W-1:0]   i_second_byte = '0;
    logic [DATA_W-1:0]   i_input_char = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [PC_W-1:0]     o_next_pc;
    logic [STATUS_W-1:0] o_status;
    logic                o_char_valid;
    logic [DATA_W-1:0]   o_char_out;
    logic                o_patch_valid;
    logic [DATA_W-1:0]   o_patch_value;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [PC_W-1:0]     i_program_length = '0;

    exec_scoreboard sb = new();
    bit             quiet = 1'b0;
    bit             hold_request = 1'b0;
    int             hold_left = 0;
    int unsigned    cycle_count = 0;

    byte_vm_instruction_execute_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_first_in_memory  (i_first_in_memory),
        .i_second_in_memory (i_second_in_memory),
        .i_first_byte       (i_first_byte),
        .i_second_byte      (i_second_byte),
        .i_input_char       (i_input_char),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_next_pc          (o_next_pc),
        .o_status           (o_status),
        .o_char_valid       (o_char_valid),
        .o_char_out         (o_char_out),
        .o_patch_valid      (o_patch_valid),
        .o_patch_value      (o_patch_value),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_program_length   (i_program_length)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check accepted result items, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result({o_next_pc, o_status, o_char_valid, o_char_out,
                             o_patch_valid, o_patch_value});
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    function automatic t_instr make_instr(logic [OPCODE_W-1:0] op, logic f1, logic f2,
                                          logic [DATA_W-1:0] b1, logic [DATA_W-1:0] b2,
                                          logic [DATA_W-1:0] ch);
        t_instr it;
        it.opcode = op;
        it.first_mem = f1;
        it.second_mem = f2;
        it.first_byte = b1;
        it.second_byte = b2;
        it.input_char = ch;
        return it;
    endfunction

    // Favor low addresses so reads hit earlier writes, and the byte extremes
    function automatic logic [DATA_W-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return DATA_W'($urandom_range(0, 15));
        if (r < 55) begin
            case ($urandom_range(0, 4))
                0: return 8'h00;
                1: return 8'h01;
                2: return 8'h7F;
                3: return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return DATA_W'($urandom_range(0, 255));
    endfunction

    function automatic t_instr random_instr();
        logic [OPCODE_W-1:0] op;
        if ($urandom_range(0, 99) < 6)
            op = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else
            op = OPCODE_W'($urandom_range(OP_MOVE, OP_IN));
        return make_instr(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          pick_byte(), pick_byte(), DATA_W'($urandom_range(0, 255)));
    endfunction

    // Keep the machine alive: drop traps and saturation, most halts too
    function automatic t_instr next_running_instr();
        t_instr  it;
        t_result peek;
        for (int tries = 0; tries < 20; tries++) begin
            it = random_instr();
            peek = sb.run_instr(it, 1'b0);
            if (peek.status == ST_FAULT || peek.next_pc == PC_W'(PROGRAM_DEPTH)) continue;
            if (peek.status == ST_FINISH && $urandom_range(0, 7) != 0) continue;
            return it;
        end
        return make_instr(OP_JUMP, 1'b0, 1'b0, 8'h00, pick_byte(), pick_byte());
    endfunction

    // Offer one item after a random idle gap; note it once accepted
    task automatic offer(input t_instr it);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= it.opcode;
        i_first_in_memory <= it.first_mem;
        i_second_in_memory <= it.second_mem;
        i_first_byte <= it.first_byte;
        i_second_byte <= it.second_byte;
        i_input_char <= it.input_char;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_instr(it);
    endtask

    // Hold the sender until every expected result item has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
    endtask

    task automatic write_length(input logic [PC_W-1:0] len);
        i_cfg_valid <= 1'b1;
        i_program_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.length_reg = len;
    endtask

    initial begin
        int              random_sent;
        int              phase;
        int              budget;
        int              noise;
        int unsigned     ending;
        logic [PC_W-1:0] new_len;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Length is zero out of reset: the machine reports finished
        offer(random_instr());
        offer(random_instr());
        drain();
        write_length(PC_W'(PROGRAM_DEPTH));

        // Stores, patches and wrapping arithmetic
        offer(make_instr(OP_MOVE, 1'b1, 1'b0, 8'h00, 8'h7F, 8'h00));
        offer(make_instr(OP_MOVE, 1'b1, 1'b0, 8'hFF, 8'h80, 8'hFF));
        offer(make_instr(OP_MOVE, 1'b0, 1'b0, 8'h05, 8'hFF, 8'h00));
        offer(make_instr(OP_ADD, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00));
        offer(make_instr(OP_ADD, 1'b0, 1'b0, 8'hFF, 8'h01, 8'h00));
        offer(make_instr(OP_SUB, 1'b0, 1'b0, 8'h00, 8'h01, 8'h00));
        offer(make_instr(OP_SUB, 1'b1, 1'b1, 8'h01, 8'hFF, 8'h00));
        offer(make_instr(OP_MUL, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'h00));
        offer(make_instr(OP_MUL, 1'b0, 1'b1, 8'h10, 8'h00, 8'h00));
        // Signed divide: overflow wraps, quotients truncate toward zero
        offer(make_instr(OP_DIV, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'h00));
        offer(make_instr(OP_DIV, 1'b0, 1'b0, 8'h07, 8'hFE, 8'h00));
        offer(make_instr(OP_DIV, 1'b0, 1'b0, 8'hF9, 8'h02, 8'h00));
        // Character output and input
        offer(make_instr(OP_OUT, 1'b0, 1'b0, 8'h41, 8'h00, 8'h00));
        offer(make_instr(OP_OUT, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00));
        offer(make_instr(OP_IN, 1'b1, 1'b0, 8'h03, 8'h00, 8'hFF));
        offer(make_instr(OP_IN, 1'b0, 1'b1, 8'h09, 8'hFF, 8'h00));
        // Branches taken and not taken, backward and forward
        offer(make_instr(OP_BR_Z, 1'b1, 1'b0, 8'h04, 8'h03, 8'h00));
        offer(make_instr(OP_BR_NZ, 1'b0, 1'b0, 8'h00, 8'h03, 8'h00));
        offer(make_instr(OP_BR_POS, 1'b0, 1'b0, 8'h7F, 8'hFF, 8'h00));
        offer(make_instr(OP_BR_NEG, 1'b1, 1'b0, 8'hFF, 8'h02, 8'h00));
        offer(make_instr(OP_BR_POS, 1'b0, 1'b0, 8'h80, 8'h05, 8'h00));
        offer(make_instr(OP_BR_NEG, 1'b0, 1'b0, 8'h00, 8'h05, 8'h00));
        // Jumps and the opcodes without a function
        offer(make_instr(OP_JUMP, 1'b0, 1'b0, 8'h7F, 8'h00, 8'h00));
        offer(make_instr(OP_SPARE_LO, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        offer(make_instr(OP_SPARE_HI, 1'b0, 1'b0, 8'h80, 8'h80, 8'h80));
        offer(make_instr(OP_JUMP, 1'b1, 1'b0, 8'h04, 8'h00, 8'h00));

        // Random phases, each with its own program length
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            drain();
            if (phase == 1) begin
                new_len = '0;
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: new_len = PC_W'(PROGRAM_DEPTH);
                    2: new_len = PC_W'(sb.pc + 1);
                    default: new_len = PC_W'($urandom_range(sb.pc + 1, PROGRAM_DEPTH));
                endcase
            end
            write_length(new_len);
            budget = $urandom_range(40, 120);
            noise = 0;
            while (budget > 0 && noise < 2 && random_sent < RANDOM_ITEMS) begin
                if (sb.halted()) begin
                    offer(random_instr());
                    noise++;
                end else begin
                    offer(next_running_instr());
                    budget--;
                    random_sent++;
                    if (random_sent == QUIET_FROM) quiet = 1'b1;
                    if (random_sent == QUIET_TO) quiet = 1'b0;
                    // Stall the output long enough to back up the input
                    if (random_sent == HOLD_AT) hold_request = 1'b1;
                end
            end
            phase++;
        end

        // Closing phase: end in a trap or in saturation, then show it sticks
        drain();
        write_length(PC_W'(PROGRAM_DEPTH));
        for (int k = 0; k < 6; k++) offer(next_running_instr());
        offer(make_instr(OP_JUMP, 1'b0, 1'b0, 8'h03, 8'h00, 8'h00));
        ending = $urandom_range(0, 3);
        case (ending)
            0: offer(make_instr(OP_DIV, 1'b0, 1'b0, 8'h09, 8'h00, 8'h00));
            1: offer(make_instr(OP_JUMP, 1'b0, 1'b0, 8'h80, 8'h00, 8'h00));
            2: offer(make_instr(OP_BR_NZ, 1'b0, 1'b0, 8'h01, 8'hF0, 8'h00));
            default: begin
                offer(make_instr(OP_JUMP, 1'b0, 1'b0, 8'h7F, 8'h00, 8'h00));
                offer(make_instr(OP_BR_POS, 1'b0, 1'b0, 8'h01, 8'h7F, 8'h00));
                offer(make_instr(OP_BR_POS, 1'b0, 1'b0, 8'h01, 8'h7F, 8'h00));
            end
        endcase
        for (int k = 0; k < 3; k++) offer(random_instr());

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
